// ===== hdl/aabb_pkg.sv =====
package aabb_pkg;

  localparam int POS_W       = 32;
  localparam int CFG_W       = 24;
  localparam int WIDE_W      = 36;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 136;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  localparam wide_t POS_MAX  = 36'sh07FFFFFFF;
  localparam wide_t POS_MIN  = 36'shF80000000;
  localparam pos_t  SAT_HIGH = 32'sh7FFFFFFF;
  localparam pos_t  SAT_LOW  = 32'sh80000000;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_BEGIN   = 1'b0,
    REQ_CONTACT = 1'b1
  } req_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] off_x;
    logic signed [CFG_W-1:0] off_y;
    logic [CFG_W-1:0]        width;
    logic [CFG_W-1:0]        height;
  } box_cfg_t;

  typedef struct packed {
    req_e  req;
    pos_t  x;
    pos_t  y;
    pos_t  vx;
    pos_t  vy;
    logic  has_vel;
    wide_t edge_l;
    wide_t edge_r;
    wide_t edge_t;
    wide_t edge_b;
    pos_t  snap_l;
    pos_t  snap_r;
    pos_t  snap_t;
    pos_t  snap_b;
  } item_t;

  typedef struct packed {
    pos_t  pos_x;
    pos_t  pos_y;
    pos_t  vel_x;
    pos_t  vel_y;
    logic  grounded;
    side_e side;
  } result_t;

  function automatic pos_t sat32(wide_t v);
    pos_t r;
    if (v > POS_MAX) begin
      r = SAT_HIGH;
    end else if (v < POS_MIN) begin
      r = SAT_LOW;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/aabb_cfg.sv =====
module aabb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [aabb_pkg::CFG_W-1:0]      cfg_data_i,
  output aabb_pkg::box_cfg_t              box_cfg_o
);

  aabb_pkg::box_cfg_t box_q, box_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    box_d = box_q;
    if (cfg_valid_i) begin
      case (aabb_pkg::cfg_reg_e'(cfg_index_i))
        aabb_pkg::REG_OFFSET_X: box_d.off_x  = cfg_data_i;
        aabb_pkg::REG_OFFSET_Y: box_d.off_y  = cfg_data_i;
        aabb_pkg::REG_WIDTH:    box_d.width  = cfg_data_i;
        aabb_pkg::REG_HEIGHT:   box_d.height = cfg_data_i;
        default:                box_d        = box_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  assign box_cfg_o = box_q;

endmodule

// ===== hdl/aabb_prep.sv =====
module aabb_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic                             advance_i,
  input  logic [aabb_pkg::IN_TDATA_W-1:0]  tdata_i,
  input  logic                             tuser_i,
  input  aabb_pkg::box_cfg_t               box_cfg_i,
  output logic                             valid_o,
  output aabb_pkg::item_t                  item_o
);

  logic            valid_q, valid_d;
  aabb_pkg::item_t item_q, item_d;
  aabb_pkg::wide_t tx, ty, tw, th, bw, bh, ox, oy;

  always_comb begin
    tx = aabb_pkg::wide_t'($signed(tdata_i[31:0]));
    ty = aabb_pkg::wide_t'($signed(tdata_i[63:32]));
    tw = aabb_pkg::wide_t'({12'd0, tdata_i[87:64]});
    th = aabb_pkg::wide_t'({12'd0, tdata_i[111:88]});
    bw = aabb_pkg::wide_t'({12'd0, box_cfg_i.width});
    bh = aabb_pkg::wide_t'({12'd0, box_cfg_i.height});
    ox = aabb_pkg::wide_t'(box_cfg_i.off_x);
    oy = aabb_pkg::wide_t'(box_cfg_i.off_y);

    item_d         = item_q;
    item_d.req     = aabb_pkg::req_e'(tuser_i);
    item_d.x       = tdata_i[31:0];
    item_d.y       = tdata_i[63:32];
    item_d.vx      = tdata_i[143:112];
    item_d.vy      = tdata_i[175:144];
    item_d.has_vel = tdata_i[176];
    item_d.edge_l  = tx - bw - ox;
    item_d.edge_r  = tx + tw - ox;
    item_d.edge_t  = ty - bh - oy;
    item_d.edge_b  = ty + th - oy;
    item_d.snap_l  = aabb_pkg::sat32(item_d.edge_l);
    item_d.snap_r  = aabb_pkg::sat32(item_d.edge_r);
    item_d.snap_t  = aabb_pkg::sat32(item_d.edge_t);
    item_d.snap_b  = aabb_pkg::sat32(item_d.edge_b);
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/aabb_resolve.sv =====
module aabb_resolve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic               taken_i,
  input  aabb_pkg::item_t    item_i,
  output logic               valid_o,
  output aabb_pkg::result_t  result_o
);

  aabb_pkg::pos_t    mx_q, mx_d, my_q, my_d, vx_q, vx_d, vy_q, vy_d;
  logic              ground_q, ground_d, vel_q, vel_d;
  logic              valid_q, valid_d;
  aabb_pkg::result_t res_q, res_d;
  aabb_pkg::side_e   side;
  aabb_pkg::wide_t   ol, orr, ot, ob, hx, hy, mxw, myw;
  logic              go_left, go_top, horiz;

  always_comb begin
    mxw     = aabb_pkg::wide_t'(mx_q);
    myw     = aabb_pkg::wide_t'(my_q);
    ol      = mxw - item_i.edge_l;
    orr     = item_i.edge_r - mxw;
    ot      = myw - item_i.edge_t;
    ob      = item_i.edge_b - myw;
    go_left = ol < orr;
    go_top  = ot < ob;
    hx      = go_left ? ol : orr;
    hy      = go_top ? ot : ob;
    horiz   = hx < hy;

    mx_d     = mx_q;
    my_d     = my_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    ground_d = ground_q;
    vel_d    = vel_q;
    side     = aabb_pkg::SIDE_NONE;

    if (item_i.req == aabb_pkg::REQ_BEGIN) begin
      mx_d     = item_i.x;
      my_d     = item_i.y;
      vx_d     = item_i.vx;
      vy_d     = item_i.vy;
      vel_d    = item_i.has_vel;
      ground_d = 1'b0;
    end else if (horiz) begin
      mx_d = go_left ? item_i.snap_l : item_i.snap_r;
      side = go_left ? aabb_pkg::SIDE_LEFT : aabb_pkg::SIDE_RIGHT;
      if (vel_q) begin
        vx_d = '0;
      end
    end else if (go_top) begin
      my_d     = item_i.snap_t;
      ground_d = 1'b1;
      side     = aabb_pkg::SIDE_TOP;
      if (vel_q && (vy_q > 0)) begin
        vy_d = '0;
      end
    end else begin
      my_d = item_i.snap_b;
      side = aabb_pkg::SIDE_BOTTOM;
      if (vel_q && (vy_q < 0)) begin
        vy_d = '0;
      end
    end

    res_d.pos_x    = mx_d;
    res_d.pos_y    = my_d;
    res_d.vel_x    = vx_d;
    res_d.vel_y    = vy_d;
    res_d.grounded = ground_d;
    res_d.side     = side;
  end

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (taken_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx_q     <= '0;
      my_q     <= '0;
      vx_q     <= '0;
      vy_q     <= '0;
      ground_q <= 1'b0;
      vel_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (fire_i) begin
        mx_q     <= mx_d;
        my_q     <= my_d;
        vx_q     <= vx_d;
        vy_q     <= vy_d;
        ground_q <= ground_d;
        vel_q    <= vel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== hdl/aabb_collision_resolver_unit.sv =====
// Each item passes the prep and resolve registers. Throughput: 1 item per
// cycle unless stalled; the mover state loops through one register stage,
// so each contact sees the state left by the item just before it.
// Reset (rst_ni low, asynchronous): mover state, grounded, velocity flag
// and box registers clear to zero; both pipeline stages empty.
module aabb_collision_resolver_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [aabb_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // item_x[31:0], item_y[63:32], tile_width[87:64], tile_height[111:88],
  // start_vel_x[143:112], start_vel_y[175:144], has_velocity[176], zero pad
  input  logic [aabb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], grounded[128],
  // side_hit[131:129], zero pad
  output logic [aabb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  aabb_pkg::box_cfg_t box_cfg;
  aabb_pkg::item_t    item;
  aabb_pkg::result_t  result;
  logic               s1_valid, out_valid, out_ready, load, advance;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_ready;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid && out_ready;

  aabb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .box_cfg_o   (box_cfg)
  );

  aabb_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .advance_i (advance),
    .tdata_i   (s_axis_tdata),
    .tuser_i   (s_axis_tuser),
    .box_cfg_i (box_cfg),
    .valid_o   (s1_valid),
    .item_o    (item)
  );

  aabb_resolve u_resolve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .taken_i  (m_axis_tready),
    .item_i   (item),
    .valid_o  (out_valid),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, result.side, result.grounded, result.vel_y,
                          result.vel_x, result.pos_y, result.pos_x};

endmodule

// ===== hdl/aabb_chk.sv =====
module aabb_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [aabb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic [2:0] side_hit;
  logic       grounded;

  assign side_hit = m_axis_tdata[131:129];
  assign grounded = m_axis_tdata[128];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (side_hit == aabb_pkg::SIDE_TOP) |-> grounded)
    else $error("top landing without grounded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (side_hit == aabb_pkg::SIDE_NONE) |-> !grounded)
    else $error("begin result shows grounded");

endmodule

bind aabb_collision_resolver_unit aabb_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/aabb_collision_resolver_unit_tb.sv =====
module aabb_collision_resolver_unit_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 280;
  localparam int PHASES       = 6;
  localparam int STALL_AT     = 150;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [aabb_pkg::CFG_W-1:0] cfg_val_t;

  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_FULL = 2'd1,
    IDLE_SOME = 2'd2
  } idle_e;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    aabb_pkg::cfg_reg_e              cfg_idx;
    cfg_val_t                        cfg_val;
    aabb_pkg::req_e                  req;
    logic [aabb_pkg::IN_TDATA_W-1:0] data;
    logic                            has_exp;
    aabb_pkg::result_t               exp;
  } stim_row_t;

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [aabb_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [aabb_pkg::CFG_W-1:0]       cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [aabb_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tuser  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [aabb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic signed [aabb_pkg::CFG_W-1:0] box_off_x  = '0;
  logic signed [aabb_pkg::CFG_W-1:0] box_off_y  = '0;
  logic [aabb_pkg::CFG_W-1:0]        box_width  = '0;
  logic [aabb_pkg::CFG_W-1:0]        box_height = '0;

  aabb_pkg::pos_t mv_x         = '0;
  aabb_pkg::pos_t mv_y         = '0;
  aabb_pkg::pos_t mv_vx        = '0;
  aabb_pkg::pos_t mv_vy        = '0;
  logic           mv_grounded  = 1'b0;
  logic           mv_has_vel   = 1'b0;

  aabb_pkg::result_t expected_results[$];
  int      errors       = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      reg_writes   = 0;
  int      side_hits[5] = '{0, 0, 0, 0, 0};
  idle_e   snd_idle     = IDLE_SOME;
  idle_e   rcv_idle     = IDLE_SOME;

  aabb_collision_resolver_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int draw_gap(input idle_e mode);
    case (mode)
      IDLE_FULL: return $urandom_range(0, 14);
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default:   return 0;
    endcase
  endfunction

  function automatic aabb_pkg::pos_t clamp32(input longint v);
    if (v > longint'(aabb_pkg::SAT_HIGH)) return aabb_pkg::SAT_HIGH;
    if (v < longint'(aabb_pkg::SAT_LOW)) return aabb_pkg::SAT_LOW;
    return aabb_pkg::pos_t'(v);
  endfunction

  function automatic logic [aabb_pkg::IN_TDATA_W-1:0] pack_item(
      input aabb_pkg::pos_t x, input aabb_pkg::pos_t y,
      input cfg_val_t tw, input cfg_val_t th,
      input aabb_pkg::pos_t vx, input aabb_pkg::pos_t vy,
      input logic hv);
    return {7'b0, hv, vy, vx, th, tw, y, x};
  endfunction

  function automatic aabb_pkg::result_t mk_result(
      input aabb_pkg::pos_t px, input aabb_pkg::pos_t py, input aabb_pkg::pos_t vx,
      input aabb_pkg::pos_t vy, input logic g, input aabb_pkg::side_e s);
    aabb_pkg::result_t r;
    r.pos_x    = px;
    r.pos_y    = py;
    r.vel_x    = vx;
    r.vel_y    = vy;
    r.grounded = g;
    r.side     = s;
    return r;
  endfunction

  // Advance the mover by one transaction and return the result it produces.
  function automatic aabb_pkg::result_t resolve_mover(
      input aabb_pkg::req_e req, input logic [aabb_pkg::IN_TDATA_W-1:0] d);
    longint          ox, oy, bw, bh, tx, ty, tw, th, px, py;
    longint          ov_l, ov_r, ov_t, ov_b, mx, my;
    aabb_pkg::side_e side;
    side = aabb_pkg::SIDE_NONE;
    if (req == aabb_pkg::REQ_BEGIN) begin
      mv_x        = d[31:0];
      mv_y        = d[63:32];
      mv_vx       = d[143:112];
      mv_vy       = d[175:144];
      mv_has_vel  = d[176];
      mv_grounded = 1'b0;
    end else begin
      ox   = longint'(box_off_x);
      oy   = longint'(box_off_y);
      bw   = longint'(box_width);
      bh   = longint'(box_height);
      tx   = longint'($signed(d[31:0]));
      ty   = longint'($signed(d[63:32]));
      tw   = longint'(d[87:64]);
      th   = longint'(d[111:88]);
      px   = longint'(mv_x) + ox;
      py   = longint'(mv_y) + oy;
      ov_l = px + bw - tx;
      ov_r = tx + tw - px;
      ov_t = py + bh - ty;
      ov_b = ty + th - py;
      mx   = (ov_l < ov_r) ? ov_l : ov_r;
      my   = (ov_t < ov_b) ? ov_t : ov_b;
      if (mx < my) begin
        if (ov_l < ov_r) begin
          mv_x = clamp32(tx - bw - ox);
          side = aabb_pkg::SIDE_LEFT;
        end else begin
          mv_x = clamp32(tx + tw - ox);
          side = aabb_pkg::SIDE_RIGHT;
        end
        if (mv_has_vel) mv_vx = '0;
      end else if (ov_t < ov_b) begin
        mv_y        = clamp32(ty - bh - oy);
        mv_grounded = 1'b1;
        side        = aabb_pkg::SIDE_TOP;
        if (mv_has_vel && mv_vy > 0) mv_vy = '0;
      end else begin
        mv_y = clamp32(ty + th - oy);
        side = aabb_pkg::SIDE_BOTTOM;
        if (mv_has_vel && mv_vy < 0) mv_vy = '0;
      end
    end
    return mk_result(mv_x, mv_y, mv_vx, mv_vy, mv_grounded, side);
  endfunction

  function automatic stim_row_t item_row(
      input aabb_pkg::req_e req, input aabb_pkg::pos_t x, input aabb_pkg::pos_t y,
      input cfg_val_t tw, input cfg_val_t th,
      input aabb_pkg::pos_t vx, input aabb_pkg::pos_t vy, input logic hv);
    stim_row_t r;
    r.kind    = ROW_ITEM;
    r.cfg_idx = aabb_pkg::REG_OFFSET_X;
    r.cfg_val = '0;
    r.req     = req;
    r.data    = pack_item(x, y, tw, th, vx, vy, hv);
    r.has_exp = 1'b0;
    r.exp     = '0;
    return r;
  endfunction

  function automatic stim_row_t with_result(input stim_row_t r, input aabb_pkg::result_t e);
    stim_row_t o;
    o         = r;
    o.has_exp = 1'b1;
    o.exp     = e;
    return o;
  endfunction

  function automatic stim_row_t cfg_row(input aabb_pkg::cfg_reg_e idx, input cfg_val_t v);
    stim_row_t r;
    r         = item_row(aabb_pkg::REQ_BEGIN, '0, '0, '0, '0, '0, '0, 1'b0);
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Drain the pipeline, then write one box register.
  task automatic write_box_reg(input aabb_pkg::cfg_reg_e idx, input cfg_val_t val);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      aabb_pkg::REG_OFFSET_X: box_off_x  = val;
      aabb_pkg::REG_OFFSET_Y: box_off_y  = val;
      aabb_pkg::REG_WIDTH:    box_width  = val;
      aabb_pkg::REG_HEIGHT:   box_height = val;
      default:                ;
    endcase
  endtask

  task automatic drive_item(input aabb_pkg::req_e req,
                            input logic [aabb_pkg::IN_TDATA_W-1:0] data,
                            input logic has_exp, input aabb_pkg::result_t exp);
    int                gap;
    aabb_pkg::result_t pred;
    gap = draw_gap(snd_idle);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = resolve_mover(req, data);
    expected_results.push_back(has_exp ? exp : pred);
    items_sent++;
  endtask

  // Mostly frames of a begin and contacts placed over the collider, plus raw noise.
  task automatic run_random(input int count);
    int             done;
    int             n;
    longint         tw, th, span_x, span_y;
    aabb_pkg::pos_t bx, by, bvx, bvy, tx, ty;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 4) == 0) begin
        drive_item(aabb_pkg::req_e'($urandom_range(0, 1)),
                   pack_item($urandom(), $urandom(), cfg_val_t'($urandom()),
                             cfg_val_t'($urandom()), $urandom(), $urandom(),
                             1'($urandom_range(0, 1))),
                   1'b0, '0);
        done++;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          bx = $urandom();
          by = $urandom();
        end else begin
          bx = $urandom_range(0, 'h200000) - 'h100000;
          by = $urandom_range(0, 'h200000) - 'h100000;
        end
        bvx = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 'h1000) - 'h800;
        bvy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 'h1000) - 'h800;
        drive_item(aabb_pkg::REQ_BEGIN,
                   pack_item(bx, by, cfg_val_t'($urandom()), cfg_val_t'($urandom()),
                             bvx, bvy, $urandom_range(0, 4) != 0),
                   1'b0, '0);
        done++;
        n = $urandom_range(1, 8);
        repeat (n) begin
          tw = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 'hFFFFFF))
                                           : longint'($urandom_range(0, 'h4000));
          th = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 'hFFFFFF))
                                           : longint'($urandom_range(0, 'h4000));
          span_x = longint'(box_width) + tw;
          span_y = longint'(box_height) + th;
          tx = aabb_pkg::pos_t'(longint'(mv_x) + longint'(box_off_x) - tw +
                                longint'($urandom_range(0, 32'(span_x))));
          ty = aabb_pkg::pos_t'(longint'(mv_y) + longint'(box_off_y) - th +
                                longint'($urandom_range(0, 32'(span_y))));
          drive_item(aabb_pkg::REQ_CONTACT,
                     pack_item(tx, ty, tw[aabb_pkg::CFG_W-1:0], th[aabb_pkg::CFG_W-1:0],
                               $urandom(), $urandom(), 1'($urandom_range(0, 1))),
                     1'b0, '0);
          done++;
        end
      end
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d results pending", $time, IDLE_LIMIT,
             expected_results.size());
    $display("aabb_collision_resolver_unit_tb NOT OK");
    $finish;
  end

  initial begin
    int                               gap;
    aabb_pkg::result_t                want;
    logic [aabb_pkg::OUT_TDATA_W-1:0] got;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen == STALL_AT) begin
        // Hold off long enough for the block to fill and stall its input.
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end else begin
        gap = draw_gap(rcv_idle);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = m_axis_tdata;
      results_seen++;
      if (got[131:129] <= 3'd4) side_hits[got[131:129]]++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("pos_x", want.pos_x, got[31:0]);
        check_field("pos_y", want.pos_y, got[63:32]);
        check_field("vel_x", want.vel_x, got[95:64]);
        check_field("vel_y", want.vel_y, got[127:96]);
        check_field("grounded", want.grounded, got[128]);
        check_field("side_hit", want.side, got[131:129]);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    cfg_val_t  ox, oy, bw, bh;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(with_result(item_row(aabb_pkg::REQ_CONTACT, 0, 0, 0, 0, 0, 0, 1'b0),
                               mk_result(0, 0, 0, 0, 1'b0, aabb_pkg::SIDE_BOTTOM)));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_X, 'h0));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_Y, 'h0));
    rows.push_back(cfg_row(aabb_pkg::REG_WIDTH, 'h1000));
    rows.push_back(cfg_row(aabb_pkg::REG_HEIGHT, 'h1000));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, 'h1000, 'h1000, 0, 0,
                                        'h100, 'h200, 1'b1),
                               mk_result('h1000, 'h1000, 'h100, 'h200, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h1000, 'h1F00, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, 'h1000, 'h1000, 0, 0,
                                        -32'sh300, -32'sh400, 1'b1),
                               mk_result('h1000, 'h1000, -32'sh300, -32'sh400, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h1000, 'h0100, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h1F00, 'h1100, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h0000, 'h1000, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h1000, 'h1100, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h1000, 'h0000, 'h1000, 'h8000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h40000000, -32'sh40000000,
                            'h100, 'h100, aabb_pkg::SAT_HIGH, aabb_pkg::SAT_LOW, 1'b1));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, 'h2000, 'h2000,
                                        'hFFFFFF, 'hFFFFFF, 'h500, 'h600, 1'b0),
                               mk_result('h2000, 'h2000, 'h500, 'h600, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h2000, 'h2F00, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, 'h2F00, 'h1F00, 'h1000, 'h1000,
                            0, 0, 1'b0));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, aabb_pkg::SAT_HIGH,
                                        aabb_pkg::SAT_LOW, 'hFFFFFF, 'hFFFFFF,
                                        aabb_pkg::SAT_LOW, aabb_pkg::SAT_HIGH, 1'b1),
                               mk_result(aabb_pkg::SAT_HIGH, aabb_pkg::SAT_LOW,
                                         aabb_pkg::SAT_LOW, aabb_pkg::SAT_HIGH, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(item_row(aabb_pkg::REQ_CONTACT, aabb_pkg::SAT_LOW, aabb_pkg::SAT_LOW,
                            'hFFFFFF, 'hFFFFFF, aabb_pkg::SAT_HIGH, aabb_pkg::SAT_HIGH,
                            1'b1));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_X, 'h7FFFFF));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_Y, 'h7FFFFF));
    rows.push_back(cfg_row(aabb_pkg::REG_WIDTH, 'hFFFFFF));
    rows.push_back(cfg_row(aabb_pkg::REG_HEIGHT, 'hFFFFFF));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, aabb_pkg::SAT_HIGH, 0, 0, 0,
                                        'h100, 0, 1'b1),
                               mk_result(aabb_pkg::SAT_HIGH, 0, 'h100, 0, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_CONTACT, aabb_pkg::SAT_HIGH,
                                        'h7FFFFF, 'hFFFFFF, 'hFFFFFF, 0, 0, 1'b0),
                               mk_result(aabb_pkg::SAT_HIGH, 0, 0, 0, 1'b0,
                                         aabb_pkg::SIDE_RIGHT)));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_X, 'h800000));
    rows.push_back(cfg_row(aabb_pkg::REG_OFFSET_Y, 'h0));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_BEGIN, aabb_pkg::SAT_LOW, 0, 0, 0,
                                        -32'sh100, 'h100, 1'b1),
                               mk_result(aabb_pkg::SAT_LOW, 0, -32'sh100, 'h100, 1'b0,
                                         aabb_pkg::SIDE_NONE)));
    rows.push_back(with_result(item_row(aabb_pkg::REQ_CONTACT, aabb_pkg::SAT_LOW, 0, 0,
                                        'hFFFFFF, 0, 0, 1'b0),
                               mk_result(aabb_pkg::SAT_LOW, 0, 0, 'h100, 1'b0,
                                         aabb_pkg::SIDE_LEFT)));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_box_reg(rows[i].cfg_idx, rows[i].cfg_val);
      end else begin
        drive_item(rows[i].req, rows[i].data, rows[i].has_exp, rows[i].exp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          ox = 'h0; oy = 'h0; bw = 'h1000; bh = 'h1000;
        end
        1: begin
          ox = 'h7FFFFF; oy = 'h800000; bw = 'hFFFFFF; bh = 'h0;
        end
        2: begin
          ox = 'h800000; oy = 'h7FFFFF; bw = 'h0; bh = 'hFFFFFF;
        end
        3: begin
          ox = 'h0; oy = 'h0; bw = 'h0; bh = 'h0;
        end
        4: begin
          ox = cfg_val_t'($urandom_range(0, 'h4000) - 'h2000);
          oy = cfg_val_t'($urandom_range(0, 'h4000) - 'h2000);
          bw = cfg_val_t'($urandom_range(0, 'h8000));
          bh = cfg_val_t'($urandom_range(0, 'h8000));
        end
        default: begin
          ox = cfg_val_t'($urandom());
          oy = cfg_val_t'($urandom());
          bw = cfg_val_t'($urandom());
          bh = cfg_val_t'($urandom());
        end
      endcase
      write_box_reg(aabb_pkg::REG_OFFSET_X, ox);
      write_box_reg(aabb_pkg::REG_OFFSET_Y, oy);
      write_box_reg(aabb_pkg::REG_WIDTH, bw);
      write_box_reg(aabb_pkg::REG_HEIGHT, bh);
      snd_idle = idle_e'(p % 3);
      rcv_idle = idle_e'((p + 2) % 3);
      run_random(PHASE_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end

    $display("Ran %0d items through %0d register writes, %0d results checked, %0d errors;",
             items_sent, reg_writes, results_seen, errors);
    $display("sides seen: begin %0d left %0d right %0d top %0d bottom %0d, one %0d-cycle stall",
             side_hits[0], side_hits[1], side_hits[2], side_hits[3], side_hits[4],
             STALL_CYCLES);
    if (errors == 0) begin
      $display("aabb_collision_resolver_unit_tb OK");
    end else begin
      $display("aabb_collision_resolver_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
